// File: src/blr_pkg.sv
// shared types, constants and the control program of the rate-limited lowpass
// no dependencies; used by the sequencer, the datapath and the top level

package blr_pkg;

  // data and arithmetic widths
  localparam int DATA_WIDTH = 32;
  localparam int OPND_W     = 33;
  localparam int PROD_W     = 66;
  localparam int ACC_W      = 80;
  localparam int TMP_W      = 64;
  localparam int INTEG_W    = 48;
  localparam int WIDE_LIMIT = 62;
  localparam int DECAY_FRAC = 30;

  // 0.95 in Q0.30
  localparam logic signed [OPND_W-1:0] DECAY_Q = 33'sd1020054733;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_B0,
    REG_COEF_A1,
    REG_COEF_A2,
    REG_INTEGRAL_GAIN,
    REG_MAX_STEP
  } reg_idx_e;

  // multiplier operand selects
  typedef enum logic [2:0] {
    OPA_B0, OPA_B0X2, OPA_A1, OPA_A2, OPA_KI, OPA_DECAY
  } opa_e;

  typedef enum logic [2:0] {
    OPB_X, OPB_D1, OPB_D2, OPB_Y, OPB_Y2, OPB_DIFF, OPB_SUMLO, OPB_SUMHI
  } opb_e;

  // accumulator operation on the registered product
  typedef enum logic [2:0] {
    AC_HOLD, AC_LOAD, AC_LOADH, AC_ADD, AC_SUB
  } acc_op_e;

  // datapath actions
  typedef enum logic [2:0] {
    ACT_NONE,  // nothing
    ACT_RND,   // temp <= rounded accumulator
    ACT_STEP,  // limited increment
    ACT_OUT,   // output history update
    ACT_DIFF,  // temp <= sample minus output
    ACT_IADD,  // temp <= saturated integral plus temp
    ACT_DECAY, // integral <= decayed sum, input history shift, result
    ACT_LOAD   // load base value, result
  } act_e;

  typedef struct packed {
    logic    wait_in;
    logic    br_load;
    logic    fin;
    opa_e    opa;
    opb_e    opb;
    acc_op_e acc_op;
    act_e    act;
  } uword_t;

  typedef struct packed {
    uword_t word;
    logic   fire;
  } cmd_t;

  // program counter
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
  localparam logic [PC_W-1:0] PC_LOAD = 5'd19;

  // control store: one word per step
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{wait_in: 1'b0, br_load: 1'b0, fin: 1'b0, opa: OPA_B0, opb: OPB_X,
          acc_op: AC_HOLD, act: ACT_NONE};
    unique case (pc)
      5'd0:  w.wait_in = 1'b1;
      5'd1:  begin
        w.br_load = 1'b1;
        w.opa = OPA_B0;
        w.opb = OPB_X;
      end
      5'd2:  begin
        w.opa = OPA_B0X2;
        w.opb = OPB_D1;
        w.acc_op = AC_LOAD;
      end
      5'd3:  begin
        w.opa = OPA_B0;
        w.opb = OPB_D2;
        w.acc_op = AC_ADD;
      end
      5'd4:  begin
        w.opa = OPA_A1;
        w.opb = OPB_Y;
        w.acc_op = AC_ADD;
      end
      5'd5:  begin
        w.opa = OPA_A2;
        w.opb = OPB_Y2;
        w.acc_op = AC_SUB;
      end
      5'd6:  w.acc_op = AC_SUB;
      5'd7:  w.act = ACT_RND;
      5'd8:  w.act = ACT_STEP;
      5'd9:  w.act = ACT_OUT;
      5'd10: w.act = ACT_DIFF;
      5'd11: begin
        w.opa = OPA_KI;
        w.opb = OPB_DIFF;
      end
      5'd12: w.acc_op = AC_LOAD;
      5'd13: w.act = ACT_RND;
      5'd14: w.act = ACT_IADD;
      5'd15: begin
        w.opa = OPA_DECAY;
        w.opb = OPB_SUMHI;
      end
      5'd16: begin
        w.opa = OPA_DECAY;
        w.opb = OPB_SUMLO;
        w.acc_op = AC_LOADH;
      end
      5'd17: w.acc_op = AC_ADD;
      5'd18: begin
        w.act = ACT_DECAY;
        w.fin = 1'b1;
      end
      5'd19: begin
        w.act = ACT_LOAD;
        w.fin = 1'b1;
      end
      default: w.act = ACT_NONE;
    endcase
    return w;
  endfunction

endpackage

// File: src/biquad_lowpass_rate_limited.sv
// Rate-limited second-order lowpass with a leaky integral term.
// Input channel: opcode_i/sample_i under in_valid_i, stalled by in_stall_o.
//   opcode 0 filters one Q16.16 sample, opcode 1 loads the sample as base
//   value into every history register and clears the integral.
// Output channel: filtered_o/last_step_o under out_valid_o, stalled by
//   out_stall_i; one result beat for every input beat, in order.
// Configuration: cfg_we_i writes cfg_data_i into the register chosen by
//   cfg_idx_i (b0, a1, a2, integral gain, max step); write only while idle.
// Sequence: the 20-step control program passes the eight products of a
//   filter beat one at a time through a single 33x33 multiplier; a load
//   beat branches to the load step. Each beat's result is registered from
//   its finishing step, and a new beat is accepted only at the idle step.
// Stalls: a result waits in the output register; a new beat is accepted
//   meanwhile, and the program holds at its last step while the register
//   is still full. Reset clears all history, coefficients and the integral;
//   the block is ready for a beat right after reset.
// Depends on blr_pkg, blr_seq and blr_dpath.

module biquad_lowpass_rate_limited #(
  parameter int COEF_FRAC = 30
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  opcode_i,
  input  logic signed [blr_pkg::DATA_WIDTH-1:0] sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [blr_pkg::DATA_WIDTH-1:0] filtered_o,
  output logic signed [blr_pkg::DATA_WIDTH-1:0] last_step_o,
  input  logic                                  cfg_we_i,
  input  logic        [blr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic        [blr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic        [30:0]                    coef_b0_q;
  logic signed [31:0]                    coef_a1_q;
  logic signed [31:0]                    coef_a2_q;
  logic        [30:0]                    integral_gain_q;
  logic        [30:0]                    max_step_q;
  logic                                  out_valid_q;
  logic signed [blr_pkg::DATA_WIDTH-1:0] filtered_q, last_step_q;
  logic signed [blr_pkg::DATA_WIDTH-1:0] res_filtered, res_step;
  logic                                  out_busy;
  blr_pkg::cmd_t                         cmd;

  assign out_busy = out_valid_q && out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0_q       <= '0;
      coef_a1_q       <= '0;
      coef_a2_q       <= '0;
      integral_gain_q <= '0;
      max_step_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        blr_pkg::REG_COEF_B0:       coef_b0_q       <= cfg_data_i[30:0];
        blr_pkg::REG_COEF_A1:       coef_a1_q       <= $signed(cfg_data_i[31:0]);
        blr_pkg::REG_COEF_A2:       coef_a2_q       <= $signed(cfg_data_i[31:0]);
        blr_pkg::REG_INTEGRAL_GAIN: integral_gain_q <= cfg_data_i[30:0];
        blr_pkg::REG_MAX_STEP:      max_step_q      <= cfg_data_i[30:0];
        default:                    coef_b0_q       <= coef_b0_q;
      endcase
    end
  end

  // step counter and control store
  blr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .out_busy_i (out_busy),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // arithmetic and filter state
  blr_dpath #(
    .COEF_FRAC (COEF_FRAC)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sample_i        (sample_i),
    .coef_b0_i       (coef_b0_q),
    .coef_a1_i       (coef_a1_q),
    .coef_a2_i       (coef_a2_q),
    .integral_gain_i (integral_gain_q),
    .max_step_i      (max_step_q),
    .res_filtered_o  (res_filtered),
    .res_step_o      (res_step)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.fire && cmd.word.fin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.fire && cmd.word.fin) begin
      filtered_q  <= res_filtered;
      last_step_q <= res_step;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign last_step_o = last_step_q;

`ifndef SYNTHESIS
  // a finishing step always leaves a result beat behind
  a_fin_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fire && cmd.word.fin |=> out_valid_q)
    else $error("finishing step left no result beat");

  // a finishing step never overwrites a result that is still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fire && cmd.word.fin |-> !(out_valid_q && out_stall_i))
    else $error("held result overwritten");

  // an accepted beat moves the program off the idle step
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");
`endif

endmodule

// File: src/blr_seq.sv
// step counter and control store readout for the rate-limited lowpass
// depends on blr_pkg for the control word and the program

module blr_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          opcode_i,
  input  logic          out_busy_i,
  output logic          in_stall_o,
  output blr_pkg::cmd_t cmd_o
);

  logic [blr_pkg::PC_W-1:0] pc_q, pc_d;
  logic                     op_q;
  blr_pkg::uword_t          word;
  logic                     hold;

  // current control word and stall conditions
  always_comb begin
    word = blr_pkg::ucode(pc_q);
    hold = (word.wait_in && !in_valid_i) || (word.fin && out_busy_i);
  end

  // next step: hold, return to idle, branch to load, or fall through
  always_comb begin
    priority if (hold) begin
      pc_d = pc_q;
    end else if (word.fin) begin
      pc_d = blr_pkg::PC_IDLE;
    end else if (word.br_load && op_q) begin
      pc_d = blr_pkg::PC_LOAD;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= blr_pkg::PC_IDLE;
      op_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (word.wait_in && in_valid_i) begin
        op_q <= opcode_i;
      end
    end
  end

  assign in_stall_o  = !word.wait_in;
  assign cmd_o.word  = word;
  assign cmd_o.fire  = !hold;

endmodule

// File: src/blr_dpath.sv
// shared multiplier, accumulator and filter state of the rate-limited lowpass
// depends on blr_pkg; driven by the control word from blr_seq

module blr_dpath #(
  parameter int COEF_FRAC = 30
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  blr_pkg::cmd_t                         cmd_i,
  input  logic signed [blr_pkg::DATA_WIDTH-1:0] sample_i,
  input  logic        [30:0]                    coef_b0_i,
  input  logic signed [31:0]                    coef_a1_i,
  input  logic signed [31:0]                    coef_a2_i,
  input  logic        [30:0]                    integral_gain_i,
  input  logic        [30:0]                    max_step_i,
  output logic signed [blr_pkg::DATA_WIDTH-1:0] res_filtered_o,
  output logic signed [blr_pkg::DATA_WIDTH-1:0] res_step_o
);

  localparam int DW     = blr_pkg::DATA_WIDTH;
  localparam int OW     = blr_pkg::OPND_W;
  localparam int PW     = blr_pkg::PROD_W;
  localparam int AW     = blr_pkg::ACC_W;
  localparam int TW     = blr_pkg::TMP_W;
  localparam int IW     = blr_pkg::INTEG_W;
  localparam int SW     = TW + 2;

  // round half up by k bits, then saturate to w signed bits
  function automatic logic signed [TW-1:0] rnd_sat(input logic signed [AW-1:0] v,
                                                  input int k, input int w);
    logic signed [AW-1:0] r;
    logic signed [AW-1:0] mx;
    logic signed [AW-1:0] mn;
    r  = (v + (AW'(1) <<< (k - 1))) >>> k;
    mx = (AW'(1) <<< (w - 1)) - AW'(1);
    mn = -mx - AW'(1);
    if (r > mx) begin
      r = mx;
    end else if (r < mn) begin
      r = mn;
    end
    return r[TW-1:0];
  endfunction

  // saturate to w signed bits
  function automatic logic signed [SW-1:0] sat(input logic signed [SW-1:0] v, input int w);
    logic signed [SW-1:0] mx;
    logic signed [SW-1:0] mn;
    mx = (SW'(1) <<< (w - 1)) - SW'(1);
    mn = -mx - SW'(1);
    if (v > mx) begin
      return mx;
    end else if (v < mn) begin
      return mn;
    end
    return v;
  endfunction

  logic signed [DW-1:0] x_q;
  logic signed [DW-1:0] d1_q, d2_q, y_q, y2_q, step_q;
  logic signed [IW-1:0] integ_q;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [AW-1:0] acc_q;
  logic signed [TW-1:0] t_q;

  logic signed [OW-1:0] opa_v, opb_v;
  logic signed [AW-1:0] prod_ext;
  logic signed [TW-1:0] rnd_coef, rnd_decay;
  logic signed [SW-1:0] step_sat, y_sat, iadd_sat;
  logic signed [DW-1:0] lim, stp;
  logic signed [TW-1:0] diff;
  logic                 accept, fire;

  assign accept = cmd_i.word.wait_in && cmd_i.fire;
  assign fire   = cmd_i.fire;

  // multiplier operand selection
  always_comb begin
    unique case (cmd_i.word.opa)
      blr_pkg::OPA_B0:    opa_v = $signed({2'b00, coef_b0_i});
      blr_pkg::OPA_B0X2:  opa_v = $signed({1'b0, coef_b0_i, 1'b0});
      blr_pkg::OPA_A1:    opa_v = OW'(coef_a1_i);
      blr_pkg::OPA_A2:    opa_v = OW'(coef_a2_i);
      blr_pkg::OPA_KI:    opa_v = $signed({2'b00, integral_gain_i});
      blr_pkg::OPA_DECAY: opa_v = blr_pkg::DECAY_Q;
      default:            opa_v = '0;
    endcase
    unique case (cmd_i.word.opb)
      blr_pkg::OPB_X:     opb_v = OW'(x_q);
      blr_pkg::OPB_D1:    opb_v = OW'(d1_q);
      blr_pkg::OPB_D2:    opb_v = OW'(d2_q);
      blr_pkg::OPB_Y:     opb_v = OW'(y_q);
      blr_pkg::OPB_Y2:    opb_v = OW'(y2_q);
      blr_pkg::OPB_DIFF:  opb_v = t_q[OW-1:0];
      blr_pkg::OPB_SUMLO: opb_v = $signed({1'b0, t_q[31:0]});
      blr_pkg::OPB_SUMHI: opb_v = OW'($signed(t_q[IW-1:32]));
      default:            opb_v = '0;
    endcase
  end

  assign prod_d   = opa_v * opb_v;
  assign prod_ext = AW'(prod_q);

  // rounding, saturation and limiting arithmetic
  always_comb begin
    rnd_coef  = rnd_sat(acc_q, COEF_FRAC, blr_pkg::WIDE_LIMIT);
    rnd_decay = rnd_sat(acc_q, blr_pkg::DECAY_FRAC, IW);
    step_sat  = sat(SW'(t_q) - SW'(y_q) + SW'(integ_q), DW);
    lim       = DW'($signed({1'b0, max_step_i}));
    stp       = step_sat[DW-1:0];
    if (max_step_i != '0) begin
      if (stp > lim) begin
        stp = lim;
      end else if (stp < -lim) begin
        stp = -lim;
      end
    end
    y_sat     = sat(SW'(y_q) + SW'(step_q), DW);
    diff      = TW'(x_q) - TW'(y_q);
    iadd_sat  = sat(SW'(integ_q) + SW'(t_q), IW);
  end

  // working registers: sample, product, accumulator, temporary
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= sample_i;
    end
    prod_q <= prod_d;
    if (fire) begin
      unique case (cmd_i.word.acc_op)
        blr_pkg::AC_LOAD:  acc_q <= prod_ext;
        blr_pkg::AC_LOADH: acc_q <= prod_ext <<< 32;
        blr_pkg::AC_ADD:   acc_q <= acc_q + prod_ext;
        blr_pkg::AC_SUB:   acc_q <= acc_q - prod_ext;
        default:           acc_q <= acc_q;
      endcase
      unique case (cmd_i.word.act)
        blr_pkg::ACT_RND:  t_q <= rnd_coef;
        blr_pkg::ACT_DIFF: t_q <= diff;
        blr_pkg::ACT_IADD: t_q <= TW'(iadd_sat);
        default:           t_q <= t_q;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q    <= '0;
      d2_q    <= '0;
      y_q     <= '0;
      y2_q    <= '0;
      integ_q <= '0;
      step_q  <= '0;
    end else if (fire) begin
      unique case (cmd_i.word.act)
        blr_pkg::ACT_STEP: step_q <= stp;
        blr_pkg::ACT_OUT: begin
          y2_q <= y_q;
          y_q  <= y_sat[DW-1:0];
        end
        blr_pkg::ACT_DECAY: begin
          integ_q <= rnd_decay[IW-1:0];
          d2_q    <= d1_q;
          d1_q    <= x_q;
        end
        blr_pkg::ACT_LOAD: begin
          d1_q    <= x_q;
          d2_q    <= x_q;
          y_q     <= x_q;
          y2_q    <= x_q;
          integ_q <= '0;
          step_q  <= '0;
        end
        default: begin
          step_q <= step_q;
        end
      endcase
    end
  end

  // result of the finishing step
  assign res_filtered_o = (cmd_i.word.act == blr_pkg::ACT_LOAD) ? x_q : y_q;
  assign res_step_o     = (cmd_i.word.act == blr_pkg::ACT_LOAD) ? '0 : step_q;

endmodule
